### hdl/i2cram_pkg.sv
// Shared types, codes and reset constants of the I2C register access master.
package i2cram_pkg;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_TICK  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CFG_DEV_ADDR  = 2'd0,
    CFG_TICKS     = 2'd1,
    CFG_POLL_LIM  = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_e;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_ST_A,
    PH_ST_B,
    PH_TX_HI,
    PH_TX_LO,
    PH_AK_REL,
    PH_AK_CLK,
    PH_AK_POLL,
    PH_RX_LO,
    PH_RX_HI,
    PH_MA_LO,
    PH_MA_HI,
    PH_SP_A,
    PH_SP_B,
    PH_SE_A,
    PH_SE_B,
    PH_SR_A,
    PH_SR_B
  } phase_e;

  localparam int unsigned CfgDataW   = 10;
  localparam logic [6:0]  DevAddrRst = 7'd42;
  localparam logic [9:0]  TicksRst   = 10'd1;
  localparam logic [7:0]  PollLimRst = 8'd250;

  localparam logic [2:0]  ByteDevW   = 3'd0;
  localparam logic [2:0]  ByteReg    = 3'd1;
  localparam logic [2:0]  ByteSecond = 3'd2;
  localparam logic [2:0]  ByteFirstRx = 3'd3;
  localparam logic [2:0]  ByteLastRx = 3'd4;
  localparam logic [3:0]  BitsPerByte = 4'd8;

  typedef struct packed {
    logic [6:0] dev_addr;
    logic [9:0] ticks;
    logic [7:0] poll_lim;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  reg_addr;
    logic [15:0] write_data;
    logic        sda_in;
  } in_item_t;

  typedef struct packed {
    logic        scl_level;
    logic        sda_level;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_value;
    logic        ack_error;
    logic        request_rejected;
  } out_item_t;

endpackage

### hdl/i2cram_if.sv
// Request and result channel interfaces of the I2C register access master.
interface i2cram_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  reg_addr;
  logic [15:0] write_data;
  logic        sda_in;

  modport source (output valid, output kind, output reg_addr, output write_data,
                  output sda_in, input ready);
  modport sink   (input valid, input kind, input reg_addr, input write_data,
                  input sda_in, output ready);
endinterface

interface i2cram_res_if;
  logic        valid;
  logic        ready;
  logic        scl_level;
  logic        sda_level;
  logic        busy_res;
  logic        done_res;
  logic [15:0] read_value;
  logic        ack_error;
  logic        request_rejected;

  modport source (output valid, output scl_level, output sda_level, output busy_res,
                  output done_res, output read_value, output ack_error,
                  output request_rejected, input ready);
  modport sink   (input valid, input scl_level, input sda_level, input busy_res,
                  input done_res, input read_value, input ack_error,
                  input request_rejected, output ready);
endinterface

### hdl/i2cram_seq.sv
// Bus sequencer: transaction state and the one-beat step of the I2C master.
module i2cram_seq import i2cram_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t res_o
);

  phase_e      phase_q, phase_d;
  logic [3:0]  bit_q, bit_d;
  logic [7:0]  shift_q, shift_d;
  logic [2:0]  bidx_q, bidx_d;
  logic [9:0]  delay_q, delay_d;
  logic [7:0]  poll_q, poll_d;
  logic        rd_q, rd_d;
  logic [7:0]  reg_q, reg_d;
  logic [15:0] data_q, data_d;
  logic [15:0] acc_q, acc_d;
  logic [1:0]  lines_q, lines_d;

  logic        enter_en, do_ack, do_send, over, done, err, rej;
  phase_e      enter_ph;
  logic [9:0]  ticks_eff;
  logic [10:0] delay_inc;

  function automatic logic [1:0] enter_lines(phase_e ph, logic msb, logic last);
    logic [1:0] l;
    unique case (ph)
      PH_ST_B:                     l = 2'b10;
      PH_TX_HI:                    l = {1'b1, msb};
      PH_TX_LO:                    l = {1'b0, msb};
      PH_AK_REL, PH_RX_LO:         l = 2'b01;
      PH_MA_LO:                    l = {1'b0, last};
      PH_MA_HI:                    l = {1'b1, last};
      PH_SP_A, PH_SE_A, PH_SR_A:   l = 2'b00;
      default:                     l = 2'b11;
    endcase
    return l;
  endfunction

  assign ticks_eff = (cfg_i.ticks == '0) ? 10'd1 : cfg_i.ticks;
  assign delay_inc = {1'b0, delay_q} + 11'd1;
  assign over      = delay_inc >= {1'b0, ticks_eff};

  always_comb begin
    phase_d  = phase_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    bidx_d   = bidx_q;
    delay_d  = over ? '0 : delay_inc[9:0];
    poll_d   = poll_q;
    rd_d     = rd_q;
    reg_d    = reg_q;
    data_d   = data_q;
    acc_d    = acc_q;
    lines_d  = lines_q;
    enter_en = 1'b0;
    enter_ph = PH_IDLE;
    do_ack   = 1'b0;
    do_send  = 1'b0;
    done     = 1'b0;
    err      = 1'b0;
    rej      = 1'b0;

    if (item_i.kind == KIND_WRITE || item_i.kind == KIND_READ) begin
      delay_d = delay_q;
      if (phase_q != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        rd_d     = (item_i.kind == KIND_READ);
        reg_d    = item_i.reg_addr;
        data_d   = item_i.write_data;
        acc_d    = '0;
        bidx_d   = ByteDevW;
        enter_en = 1'b1;
        enter_ph = PH_ST_A;
      end
    end else if (item_i.kind == KIND_TICK && phase_q != PH_IDLE) begin
      unique case (phase_q)
        PH_ST_A:   begin enter_en = over; enter_ph = PH_ST_B;  end
        PH_ST_B:   begin do_send = over;                       end
        PH_TX_HI:  begin enter_en = over; enter_ph = PH_TX_LO; end
        PH_TX_LO: begin
          if (over) begin
            shift_d  = {shift_q[6:0], 1'b0};
            bit_d    = bit_q + 4'd1;
            enter_en = 1'b1;
            enter_ph = (bit_d >= BitsPerByte) ? PH_AK_REL : PH_TX_HI;
          end
        end
        PH_AK_REL: begin enter_en = over; enter_ph = PH_AK_CLK;  end
        PH_AK_CLK: begin enter_en = over; enter_ph = PH_AK_POLL; end
        PH_AK_POLL: begin
          delay_d = delay_q;
          if (!item_i.sda_in) begin
            do_ack = 1'b1;
          end else if (poll_q >= cfg_i.poll_lim) begin
            enter_en = 1'b1;
            enter_ph = rd_q ? PH_SR_A : PH_SE_A;
          end else begin
            poll_d = poll_q + 8'd1;
          end
        end
        PH_RX_LO:  begin enter_en = over; enter_ph = PH_RX_HI; end
        PH_RX_HI: begin
          if (delay_q == '0) shift_d = {shift_q[6:0], item_i.sda_in};
          if (over) begin
            bit_d    = bit_q + 4'd1;
            enter_en = 1'b1;
            if (bit_d >= BitsPerByte) begin
              if (bidx_q == ByteFirstRx) acc_d = {shift_d, acc_q[7:0]};
              else                       acc_d = {acc_q[15:8], shift_d};
              enter_ph = PH_MA_LO;
            end else begin
              enter_ph = PH_RX_LO;
            end
          end
        end
        PH_MA_LO:  begin enter_en = over; enter_ph = PH_MA_HI; end
        PH_MA_HI: begin
          if (over) begin
            enter_en = 1'b1;
            if (bidx_q >= ByteLastRx) begin
              enter_ph = PH_SP_A;
            end else begin
              bidx_d   = ByteLastRx;
              bit_d    = '0;
              shift_d  = '0;
              enter_ph = PH_RX_LO;
            end
          end
        end
        PH_SP_A:   begin enter_en = over; enter_ph = PH_SP_B; end
        PH_SE_A:   begin enter_en = over; enter_ph = PH_SE_B; end
        PH_SR_A:   begin enter_en = over; enter_ph = PH_SR_B; end
        PH_SP_B: begin
          done     = over;
          enter_en = over;
          enter_ph = PH_IDLE;
        end
        PH_SE_B: begin
          done     = over;
          err      = over;
          enter_en = over;
          enter_ph = PH_IDLE;
        end
        PH_SR_B:   begin do_ack = over; end
        default: begin
          enter_en = 1'b1;
          enter_ph = PH_IDLE;
        end
      endcase
    end else begin
      delay_d = delay_q;
    end

    if (do_ack) begin
      if (!rd_q) begin
        if (bidx_q >= ByteFirstRx) begin
          enter_en = 1'b1;
          enter_ph = PH_SP_A;
        end else begin
          bidx_d  = bidx_q + 3'd1;
          do_send = 1'b1;
        end
      end else if (bidx_q == ByteDevW) begin
        bidx_d  = ByteReg;
        do_send = 1'b1;
      end else if (bidx_q == ByteReg) begin
        bidx_d   = ByteSecond;
        enter_en = 1'b1;
        enter_ph = PH_ST_A;
      end else begin
        bidx_d   = ByteFirstRx;
        bit_d    = '0;
        shift_d  = '0;
        enter_en = 1'b1;
        enter_ph = PH_RX_LO;
      end
    end

    if (do_send) begin
      priority case (bidx_d)
        ByteDevW:   shift_d = {cfg_i.dev_addr, 1'b0};
        ByteReg:    shift_d = reg_q;
        ByteSecond: shift_d = rd_q ? {cfg_i.dev_addr, 1'b1} : data_q[15:8];
        default:    shift_d = data_q[7:0];
      endcase
      bit_d    = '0;
      enter_en = 1'b1;
      enter_ph = PH_TX_HI;
    end

    if (enter_en) begin
      phase_d = enter_ph;
      delay_d = '0;
      lines_d = enter_lines(enter_ph, shift_d[7], bidx_d == ByteLastRx);
      if (enter_ph == PH_AK_CLK || enter_ph == PH_AK_POLL) poll_d = '0;
    end

    res_o.scl_level        = lines_d[1];
    res_o.sda_level        = lines_d[0];
    res_o.busy_res         = (phase_d != PH_IDLE);
    res_o.done_res         = done;
    res_o.read_value       = (done && rd_q) ? acc_q : '0;
    res_o.ack_error        = err;
    res_o.request_rejected = rej;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      bit_q   <= '0;
      shift_q <= '0;
      bidx_q  <= '0;
      delay_q <= '0;
      poll_q  <= '0;
      rd_q    <= 1'b0;
      reg_q   <= '0;
      data_q  <= '0;
      acc_q   <= '0;
      lines_q <= 2'b11;
    end else if (step_i) begin
      phase_q <= phase_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      bidx_q  <= bidx_d;
      delay_q <= delay_d;
      poll_q  <= poll_d;
      rd_q    <= rd_d;
      reg_q   <= reg_d;
      data_q  <= data_d;
      acc_q   <= acc_d;
      lines_q <= lines_d;
    end
  end

endmodule

### hdl/i2c_register_access_master_core.sv
// Top level of the paced I2C master for 16-bit device register access.
//
//   channel | dir | beat contents
//   --------+-----+-----------------------------------------------------------
//   req_i   | in  | kind, reg_addr, write_data, sda_in
//   res_o   | out | scl_level, sda_level, busy_res, done_res, read_value,
//           |     | ack_error, request_rejected
//   cfg     | in  | cfg_we_i, cfg_idx_i, cfg_wdata_i (write only)
//
// One request beat gives one result beat; a beat is taken every cycle while req_i is ready.
// The result is computed in the cycle the beat is taken and registered.
// A two-entry output stage keeps req_i ready while one result waits on res_o.
// req_i drops ready only once both output entries are full.
// Reset restores the register defaults and an idle bus with both lines high.
module i2c_register_access_master_core import i2cram_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  i2cram_req_if.sink          req_i,
  i2cram_res_if.source        res_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t      cfg_q;
  in_item_t  item;
  out_item_t step_res, out_q, skid_q;
  logic      out_vld_q, skid_vld_q, in_fire, out_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dev_addr <= DevAddrRst;
      cfg_q.ticks    <= TicksRst;
      cfg_q.poll_lim <= PollLimRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DEV_ADDR: cfg_q.dev_addr <= cfg_wdata_i[6:0];
        CFG_TICKS:    cfg_q.ticks    <= cfg_wdata_i[9:0];
        CFG_POLL_LIM: cfg_q.poll_lim <= cfg_wdata_i[7:0];
        default:      cfg_q          <= cfg_q;
      endcase
    end
  end

  assign item.kind       = req_i.kind;
  assign item.reg_addr   = req_i.reg_addr;
  assign item.write_data = req_i.write_data;
  assign item.sda_in     = req_i.sda_in;

  assign req_i.ready = !skid_vld_q;
  assign in_fire     = req_i.valid && !skid_vld_q;
  assign out_fire    = out_vld_q && res_o.ready;

  i2cram_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_fire),
    .item_i (item),
    .cfg_i  (cfg_q),
    .res_o  (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (skid_vld_q) begin
        if (out_fire) begin
          skid_vld_q <= 1'b0;
        end
      end else if (in_fire) begin
        if (!out_vld_q || out_fire) begin
          out_vld_q <= 1'b1;
        end else begin
          skid_vld_q <= 1'b1;
        end
      end else if (out_fire) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_fire) out_q <= skid_q;
    end else if (in_fire) begin
      if (!out_vld_q || out_fire) out_q  <= step_res;
      else                        skid_q <= step_res;
    end
  end

  assign res_o.valid            = out_vld_q;
  assign res_o.scl_level        = out_q.scl_level;
  assign res_o.sda_level        = out_q.sda_level;
  assign res_o.busy_res         = out_q.busy_res;
  assign res_o.done_res         = out_q.done_res;
  assign res_o.read_value       = out_q.read_value;
  assign res_o.ack_error        = out_q.ack_error;
  assign res_o.request_rejected = out_q.request_rejected;

endmodule

### hdl/i2cram_chk.sv
// Port-level checker for the I2C register access master, bound to the top level.
module i2cram_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic        busy_i,
  input logic        done_i,
  input logic [15:0] read_value_i,
  input logic        ack_error_i,
  input logic        rejected_i
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(done_i) && $stable(busy_i))
    else $error("result beat changed while stalled");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && done_i |-> !busy_i && !rejected_i)
    else $error("finishing beat still busy or rejected");

  a_err_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && ack_error_i |-> done_i && read_value_i == 16'd0)
    else $error("ack error outside a finishing write");

  a_rej_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && rejected_i |-> busy_i)
    else $error("request rejected while idle");

  a_data_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && read_value_i != 16'd0 |-> done_i)
    else $error("read data shown outside a finishing beat");

endmodule

bind i2c_register_access_master_core i2cram_chk u_i2cram_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .busy_i       (res_o.busy_res),
  .done_i       (res_o.done_res),
  .read_value_i (res_o.read_value),
  .ack_error_i  (res_o.ack_error),
  .rejected_i   (res_o.request_rejected)
);

### tb/sv/i2cram_status_checker.sv
`timescale 1ns / 1ps
// Status checker for the I2C register access master: predicts every result beat and compares.
module i2cram_status_checker import i2cram_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  i2cram_req_if               req,
  i2cram_res_if               res,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output int unsigned         mismatch_cnt_o,
  output int unsigned         outstanding_o,
  output logic                bus_busy_o
);

  localparam logic [2:0] ByteDataLo = 3'd3;

  cfg_t        cfg;
  phase_e      phase;
  logic [3:0]  bit_cnt;
  logic [7:0]  shifter;
  logic [2:0]  byte_idx;
  logic [9:0]  delay_cnt;
  logic [7:0]  poll_cnt;
  logic        rd_op;
  logic [7:0]  reg_hold;
  logic [15:0] data_hold;
  logic [15:0] rx_word;
  logic        scl_q;
  logic        sda_q;
  out_item_t   pending_status[$];
  int unsigned mismatches = 0;

  function void go_to(phase_e ph);
    phase     = ph;
    delay_cnt = '0;
    case (ph)
      PH_ST_B:                   {scl_q, sda_q} = 2'b10;
      PH_TX_HI:                  {scl_q, sda_q} = {1'b1, shifter[7]};
      PH_TX_LO:                  {scl_q, sda_q} = {1'b0, shifter[7]};
      PH_AK_REL, PH_RX_LO:       {scl_q, sda_q} = 2'b01;
      PH_AK_CLK, PH_AK_POLL: begin
        {scl_q, sda_q} = 2'b11;
        poll_cnt = '0;
      end
      PH_MA_LO:                  {scl_q, sda_q} = {1'b0, byte_idx == ByteLastRx};
      PH_MA_HI:                  {scl_q, sda_q} = {1'b1, byte_idx == ByteLastRx};
      PH_SP_A, PH_SE_A, PH_SR_A: {scl_q, sda_q} = 2'b00;
      default:                   {scl_q, sda_q} = 2'b11;
    endcase
  endfunction

  function void load_byte();
    case (byte_idx)
      ByteDevW:   shifter = {cfg.dev_addr, 1'b0};
      ByteReg:    shifter = reg_hold;
      ByteSecond: shifter = rd_op ? {cfg.dev_addr, 1'b1} : data_hold[15:8];
      default:    shifter = data_hold[7:0];
    endcase
    bit_cnt = '0;
    go_to(PH_TX_HI);
  endfunction

  function void acked();
    if (!rd_op) begin
      if (byte_idx >= ByteDataLo) begin
        go_to(PH_SP_A);
      end else begin
        byte_idx++;
        load_byte();
      end
    end else if (byte_idx == ByteDevW) begin
      byte_idx = ByteReg;
      load_byte();
    end else if (byte_idx == ByteReg) begin
      byte_idx = ByteSecond;
      go_to(PH_ST_A);
    end else begin
      byte_idx = ByteFirstRx;
      bit_cnt  = '0;
      shifter  = '0;
      go_to(PH_RX_LO);
    end
  endfunction

  function bit interval_done();
    logic [10:0] span;
    span = (cfg.ticks == '0) ? 11'd1 : {1'b0, cfg.ticks};
    if ({1'b0, delay_cnt} + 11'd1 >= span) begin
      delay_cnt = '0;
      return 1'b1;
    end
    delay_cnt++;
    return 1'b0;
  endfunction

  function out_item_t advance_bus(in_item_t it);
    out_item_t st;
    kind_e     k;
    st = '0;
    k  = kind_e'(it.kind);
    if (k == KIND_WRITE || k == KIND_READ) begin
      if (phase != PH_IDLE) begin
        st.request_rejected = 1'b1;
      end else begin
        rd_op     = (k == KIND_READ);
        reg_hold  = it.reg_addr;
        data_hold = it.write_data;
        rx_word   = '0;
        byte_idx  = ByteDevW;
        go_to(PH_ST_A);
      end
    end else if (k == KIND_TICK && phase != PH_IDLE) begin
      case (phase)
        PH_ST_A:  if (interval_done()) go_to(PH_ST_B);
        PH_ST_B:  if (interval_done()) load_byte();
        PH_TX_HI: if (interval_done()) go_to(PH_TX_LO);
        PH_TX_LO: if (interval_done()) begin
          shifter = shifter << 1;
          bit_cnt++;
          if (bit_cnt >= BitsPerByte) go_to(PH_AK_REL);
          else go_to(PH_TX_HI);
        end
        PH_AK_REL: if (interval_done()) go_to(PH_AK_CLK);
        PH_AK_CLK: if (interval_done()) go_to(PH_AK_POLL);
        PH_AK_POLL: begin
          if (!it.sda_in) begin
            acked();
          end else if (poll_cnt >= cfg.poll_lim) begin
            if (rd_op) go_to(PH_SR_A);
            else go_to(PH_SE_A);
          end else begin
            poll_cnt++;
          end
        end
        PH_RX_LO: if (interval_done()) go_to(PH_RX_HI);
        PH_RX_HI: begin
          if (delay_cnt == '0) shifter = {shifter[6:0], it.sda_in};
          if (interval_done()) begin
            bit_cnt++;
            if (bit_cnt >= BitsPerByte) begin
              if (byte_idx == ByteFirstRx) rx_word[15:8] = shifter;
              else rx_word[7:0] = shifter;
              go_to(PH_MA_LO);
            end else begin
              go_to(PH_RX_LO);
            end
          end
        end
        PH_MA_LO: if (interval_done()) go_to(PH_MA_HI);
        PH_MA_HI: if (interval_done()) begin
          if (byte_idx >= ByteLastRx) begin
            go_to(PH_SP_A);
          end else begin
            byte_idx = ByteLastRx;
            bit_cnt  = '0;
            shifter  = '0;
            go_to(PH_RX_LO);
          end
        end
        PH_SP_A: if (interval_done()) go_to(PH_SP_B);
        PH_SE_A: if (interval_done()) go_to(PH_SE_B);
        PH_SR_A: if (interval_done()) go_to(PH_SR_B);
        PH_SP_B: if (interval_done()) begin
          st.done_res   = 1'b1;
          st.read_value = rd_op ? rx_word : 16'h0000;
          go_to(PH_IDLE);
        end
        PH_SE_B: if (interval_done()) begin
          st.done_res  = 1'b1;
          st.ack_error = 1'b1;
          go_to(PH_IDLE);
        end
        PH_SR_B: if (interval_done()) acked();
        default: go_to(PH_IDLE);
      endcase
    end
    st.scl_level = scl_q;
    st.sda_level = sda_q;
    st.busy_res  = (phase != PH_IDLE);
    return st;
  endfunction

  function automatic bit field_ok(string name, logic [15:0] want, logic [15:0] got);
    if (got === want) return 1'b1;
    $error("%s: expected %0h, got %0h", name, want, got);
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t seen;
    out_item_t want;
    bit        ok;
    if (!rst_ni) begin
      cfg       = '{dev_addr: DevAddrRst, ticks: TicksRst, poll_lim: PollLimRst};
      phase     = PH_IDLE;
      bit_cnt   = '0;
      shifter   = '0;
      byte_idx  = '0;
      delay_cnt = '0;
      poll_cnt  = '0;
      rd_op     = 1'b0;
      reg_hold  = '0;
      data_hold = '0;
      rx_word   = '0;
      scl_q     = 1'b1;
      sda_q     = 1'b1;
      pending_status.delete();
    end else begin
      if (res.valid && res.ready) begin
        seen = out_item_t'({res.scl_level, res.sda_level, res.busy_res, res.done_res,
                            res.read_value, res.ack_error, res.request_rejected});
        if (pending_status.size() == 0) begin
          $error("result beat with no status expected: %p", seen);
          mismatches++;
        end else begin
          want = pending_status.pop_front();
          ok = field_ok("scl_level", 16'(want.scl_level), 16'(seen.scl_level))
             & field_ok("sda_level", 16'(want.sda_level), 16'(seen.sda_level))
             & field_ok("busy_res", 16'(want.busy_res), 16'(seen.busy_res))
             & field_ok("done_res", 16'(want.done_res), 16'(seen.done_res))
             & field_ok("read_value", want.read_value, seen.read_value)
             & field_ok("ack_error", 16'(want.ack_error), 16'(seen.ack_error))
             & field_ok("request_rejected", 16'(want.request_rejected),
                        16'(seen.request_rejected));
          if (!ok) mismatches++;
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_DEV_ADDR: cfg.dev_addr = cfg_wdata_i[6:0];
          CFG_TICKS:    cfg.ticks    = cfg_wdata_i[9:0];
          CFG_POLL_LIM: cfg.poll_lim = cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        pending_status.push_back(advance_bus(in_item_t'({req.kind, req.reg_addr,
                                                         req.write_data, req.sda_in})));
      end
    end
    outstanding_o  <= pending_status.size();
    bus_busy_o     <= (phase != PH_IDLE);
    mismatch_cnt_o <= mismatches;
  end

endmodule

### tb/sv/i2c_register_access_master_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for the I2C register access master: register writes, requests, ticks, verdict.
module i2c_register_access_master_core_tb;
  import i2cram_pkg::*;

  localparam int unsigned RunLimit   = 1_500_000;
  localparam int unsigned ItemTarget = 1900;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [1:0]          cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  int unsigned         mismatch_cnt;
  int unsigned         outstanding;
  logic                bus_busy;
  int unsigned         burst_left;
  int unsigned         items_sent;

  i2cram_req_if req_bus ();
  i2cram_res_if res_bus ();

  i2c_register_access_master_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_bus),
    .res_o       (res_bus),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  i2cram_status_checker status_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req            (req_bus),
    .res            (res_bus),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .mismatch_cnt_o (mismatch_cnt),
    .outstanding_o  (outstanding),
    .bus_busy_o     (bus_busy)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (RunLimit) @(posedge clk_i);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned step;
    res_bus.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(20, 300);
      for (step = 0; step < span; step++) begin
        @(posedge clk_i);
        case (mode)
          0:       res_bus.ready <= 1'b1;
          1:       res_bus.ready <= ($urandom_range(0, 3) != 0);
          default: res_bus.ready <= ((step % 5) > 1);
        endcase
      end
    end
  end

  task automatic send_beat(input kind_e k, input logic [7:0] reg_a,
                           input logic [15:0] value, input logic sda);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        req_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_bus.valid      <= 1'b1;
    req_bus.kind       <= k;
    req_bus.reg_addr   <= reg_a;
    req_bus.write_data <= value;
    req_bus.sda_in     <= sda;
    do @(posedge clk_i); while (!req_bus.ready);
  endtask

  task automatic drain();
    req_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [6:0] dev, input logic [9:0] ticks,
                           input logic [7:0] lim);
    drain();
    write_reg(CFG_DEV_ADDR, CfgDataW'(dev));
    write_reg(CFG_TICKS, ticks);
    write_reg(CFG_POLL_LIM, CfgDataW'(lim));
  endtask

  // hi_pct: chance a tick samples SDA high; noise_pct: chance each of a stray request and of an idle beat
  task automatic run_access(input kind_e op, input logic [7:0] reg_a, input logic [15:0] value,
                            input int unsigned hi_pct, input int unsigned noise_pct);
    int unsigned ticks_done;
    int unsigned pick;
    ticks_done = 0;
    send_beat(op, reg_a, value, 1'($urandom));
    items_sent++;
    do begin
      pick = $urandom_range(0, 99);
      if (pick < noise_pct && ticks_done < 12) begin
        send_beat(kind_e'($urandom_range(0, 1)), 8'($urandom), 16'($urandom), 1'($urandom));
      end else if (pick < 2 * noise_pct) begin
        send_beat(KIND_NONE, 8'($urandom), 16'($urandom), 1'($urandom));
      end else begin
        send_beat(KIND_TICK, 8'($urandom), 16'($urandom), $urandom_range(0, 99) < hi_pct);
        ticks_done++;
      end
      items_sent++;
    end while (bus_busy);
  endtask

  initial begin
    kind_e       op;
    int unsigned hi;
    int unsigned r;
    logic [9:0]  ticks;
    logic [7:0]  lim;
    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = CFG_DEV_ADDR;
    cfg_wdata          = '0;
    req_bus.valid      = 1'b0;
    req_bus.kind       = KIND_TICK;
    req_bus.reg_addr   = '0;
    req_bus.write_data = '0;
    req_bus.sda_in     = 1'b1;
    burst_left         = 0;
    items_sent         = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_beat(KIND_TICK, 8'h00, 16'h0000, 1'b0);
    send_beat(KIND_TICK, 8'hFF, 16'hFFFF, 1'b1);
    send_beat(KIND_NONE, 8'hA5, 16'h5AA5, 1'b1);
    items_sent = 3;
    run_access(KIND_WRITE, 8'h00, 16'h0000, 0, 0);
    run_access(KIND_WRITE, 8'hFF, 16'hFFFF, 0, 0);
    run_access(KIND_READ, 8'h5A, 16'h0000, 50, 0);
    run_access(KIND_READ, 8'hC3, 16'hFFFF, 0, 0);
    run_access(KIND_WRITE, 8'h3C, 16'hBEEF, 30, 40);
    configure(7'h7F, 10'd2, 8'd255);
    run_access(KIND_READ, 8'h81, 16'h0000, 40, 10);
    run_access(KIND_WRITE, 8'h42, 16'h8001, 30, 10);
    configure(7'h00, 10'd1, 8'd1);
    run_access(KIND_READ, 8'hFF, 16'hFFFF, 100, 0);
    run_access(KIND_WRITE, 8'hA5, 16'h1234, 100, 0);
    run_access(KIND_WRITE, 8'h7E, 16'h7FFE, 50, 5);
    configure(7'h55, 10'd0, 8'd0);
    run_access(KIND_READ, 8'h18, 16'h0000, 50, 5);
    run_access(KIND_WRITE, 8'hE7, 16'hC0DE, 50, 5);

    while (items_sent < ItemTarget) begin
      if ($urandom_range(0, 4) == 0) begin
        r = $urandom_range(0, 9);
        ticks = (r < 6) ? 10'd1 : (r < 9) ? 10'd2 : 10'($urandom_range(3, 5));
        case ($urandom_range(0, 3))
          0:       lim = 8'($urandom_range(0, 3));
          1:       lim = 8'($urandom_range(4, 20));
          2:       lim = 8'd250;
          default: lim = 8'd255;
        endcase
        configure(7'($urandom), ticks, lim);
      end
      op = kind_e'($urandom_range(0, 1));
      hi = ($urandom_range(0, 11) == 0) ? 100 : $urandom_range(15, 65);
      run_access(op, 8'($urandom), 16'($urandom), hi, 4);
      if ($urandom_range(0, 7) == 0) drain();
    end

    configure(7'($urandom), 10'd6, 8'd0);
    run_access(KIND_WRITE, 8'($urandom), 16'($urandom), 100, 0);

    drain();
    if (mismatch_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### i2c_register_access_master_core.f
hdl/i2cram_pkg.sv
hdl/i2cram_if.sv
hdl/i2cram_seq.sv
hdl/i2c_register_access_master_core.sv
hdl/i2cram_chk.sv
tb/sv/i2cram_status_checker.sv
tb/sv/i2c_register_access_master_core_tb.sv
